/* rtl/ntt_pkg.sv */
// ntt_pkg: shared types, constants and modular helpers for the ntt core
// no dependencies; imported by every other file of the block except ntt_buf
package ntt_pkg;

	localparam int NTT_LOG_MAX_DEFAULT = 12;
	localparam int NTT_W = 30;

	// prime modulus and barrett constant floor(2^60 / p)
	localparam logic [NTT_W-1:0] NTT_P = 30'd998244353;
	localparam logic [63:0] NTT_MU_WIDE = 64'h1000_0000_0000_0000 / 64'd998244353;
	localparam logic [30:0] NTT_MU = NTT_MU_WIDE[30:0];

	// primitive 2^23-th root of unity (3^119), its inverse, and 1/2
	localparam int NTT_ROOT_LOG = 23;
	localparam logic [NTT_W-1:0] NTT_ROOT_FWD = 30'd15311432;
	localparam logic [NTT_W-1:0] NTT_ROOT_INV = 30'd469870224;
	localparam logic [NTT_W-1:0] NTT_INV2 = 30'd499122177;

	// register reset values and command codes
	localparam logic [3:0] NTT_LOG_LEN_RESET = 4'd12;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic CFG_LOG_LENGTH = 1'b0;
	localparam logic CFG_INVERSE = 1'b1;

	typedef struct packed {
		logic command;
		logic [NTT_W-1:0] sample;
		logic final_sample;
	} in_item_t;

	typedef struct packed {
		logic [NTT_W-1:0] element;
		logic final_element;
	} out_item_t;

	typedef struct packed {
		logic index;
		logic [3:0] value;
	} cfg_req_t;

	// request to and answer from the shared modular multiplier
	typedef struct packed {
		logic start;
		logic [NTT_W-1:0] a;
		logic [NTT_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic done;
		logic [NTT_W-1:0] res;
	} mm_rsp_t;

	function automatic logic [NTT_W-1:0] mod_add(input logic [NTT_W-1:0] a,
			input logic [NTT_W-1:0] b);
		logic [NTT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, NTT_P}) s = s - {1'b0, NTT_P};
		return s[NTT_W-1:0];
	endfunction

	function automatic logic [NTT_W-1:0] mod_sub(input logic [NTT_W-1:0] a,
			input logic [NTT_W-1:0] b);
		logic [NTT_W:0] s;
		if (a >= b) s = {1'b0, a} - {1'b0, b};
		else s = {1'b0, a} + {1'b0, NTT_P} - {1'b0, b};
		return s[NTT_W-1:0];
	endfunction

endpackage

/* rtl/ntt_if.sv */
// ntt_if: valid/ready channel interfaces for samples, results and config
// depends on ntt_pkg for the payload structs
interface ntt_in_if import ntt_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface ntt_out_if import ntt_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface ntt_cfg_if import ntt_pkg::*; ();
	logic valid;
	logic ready;
	cfg_req_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* rtl/ntt_mulmod.sv */
// ntt_mulmod: shared multi-cycle modular multiplier, barrett reduction
// one 31x31 multiplier reused for product, quotient estimate and q*p
module ntt_mulmod import ntt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mm_req_t req,
	output mm_rsp_t rsp
);

	logic [3:0] step_q;
	logic [30:0] x_q, y_q;
	logic [61:0] mul_q;
	logic [31:0] lo_q, r_q;
	logic [NTT_W-1:0] res_q;
	logic done_q;

	// the single multiplier, registered every cycle
	always_ff @(posedge clk) begin
		mul_q <= x_q * y_q;
	end

	// operand sequencing and final correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				4'd0: begin
					if (req.start) begin
						x_q <= {1'b0, req.a};
						y_q <= {1'b0, req.b};
						step_q <= 4'd1;
					end
				end
				4'd2: begin
					lo_q <= mul_q[31:0];
					x_q <= mul_q[59:29];
					y_q <= NTT_MU;
					step_q <= 4'd3;
				end
				4'd4: begin
					x_q <= mul_q[61:31];
					y_q <= {1'b0, NTT_P};
					step_q <= 4'd5;
				end
				4'd6: begin
					r_q <= lo_q - mul_q[31:0];
					step_q <= 4'd7;
				end
				4'd7: begin
					if (r_q >= {2'b0, NTT_P}) r_q <= r_q - {2'b0, NTT_P};
					step_q <= 4'd8;
				end
				4'd8: begin
					res_q <= (r_q >= {2'b0, NTT_P}) ? NTT_W'(r_q - {2'b0, NTT_P})
						: r_q[NTT_W-1:0];
					done_q <= 1'b1;
					step_q <= 4'd0;
				end
				default: begin
					step_q <= step_q + 4'd1;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule

/* rtl/ntt_buf.sv */
// ntt_buf: coefficient memory, one write port and one registered read port
// no dependencies beyond the address width handed down
module ntt_buf #(
	parameter int ADDR_W = 12
) (
	input logic clk,
	input logic we,
	input logic [ADDR_W-1:0] waddr,
	input logic [29:0] wdata,
	input logic [ADDR_W-1:0] raddr,
	output logic [29:0] rdata
);

	logic [29:0] mem [2**ADDR_W];
	logic [29:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/number_theoretic_transform_core.sv */
// number_theoretic_transform_core: top level, sequencer and channel logic
// depends on ntt_pkg, ntt_if, ntt_mulmod and ntt_buf
//
// Radix-2 NTT modulo 998244353. Requests on samples carry a command: a load
// writes the next residue (reduced once if at or above the modulus) into
// the buffer; the load with final_sample set starts the in-place transform
// over 2^log_length entries. Read requests then return the elements in
// natural order on results, final_element marking the last one.
// A read passes through the buffer's read register and the result register
// before it reaches results, and another read is held off while a result
// waits. The transform runs from the final load with samples.ready low: a
// bit-reversal reorder, then per pass up to 22 squarings for the twiddle
// base and butterflies that each take two passes through the shared modular
// multiplier, and for the inverse a scaling of every element.
// cfg writes log_length (index 0) and inverse (index 1); cfg.ready is
// always high and writes are meant only while the core is idle.
// Reset clears the pointers and the done flag, sets log_length 12 and
// forward direction; buffer contents are undefined until loaded. A stalled
// results channel holds its element until taken.
module number_theoretic_transform_core import ntt_pkg::*; #(
	parameter int LOG_MAX_LENGTH = NTT_LOG_MAX_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	ntt_in_if.sink samples,
	ntt_out_if.source results,
	ntt_cfg_if.sink cfg
);

	localparam int L = LOG_MAX_LENGTH;

	typedef enum logic [4:0] {
		S_IDLE, S_BR, S_BR_A, S_BR_B, S_BR_C, S_BR_D,
		S_STG, S_SQ, S_SQ_W,
		S_BF_RD1, S_BF_RD2, S_BF_CAP, S_BF_MS, S_BF_MW, S_BF_WR1, S_BF_WR2, S_BF_WW,
		S_SC_POW, S_SC_POW_W, S_SC_RD, S_SC_CAP, S_SC_W, S_FIN
	} state_t;

	state_t st_q;
	logic [3:0] log_length_q;
	logic inverse_q;
	logic [L:0] lp_q, rp_q, i_q;
	logic [L-1:0] bf_q;
	logic done_q;
	logic rd_pend_q, fin_pend_q;
	logic out_valid_q;
	out_item_t out_q;
	logic [4:0] s_q, cnt_q;
	logic [NTT_W-1:0] wn_q, w_q, u_q, t_q;

	logic [4:0] lg;
	logic [L:0] len;
	logic in_acc;
	logic [NTT_W-1:0] red_sample;
	logic mem_we;
	logic [L-1:0] mem_waddr, mem_raddr;
	logic [NTT_W-1:0] mem_wdata, mem_rdata;
	mm_req_t mm_req;
	mm_rsp_t mm_rsp;
	logic [L-1:0] rev_full;
	logic [L:0] r_idx;
	logic [L:0] bf_ext, half, hi, kk, kh;
	logic off_zero;

	ntt_buf #(.ADDR_W(L)) u_buf (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	ntt_mulmod u_mm (.clk(clk), .arst_n(arst_n), .req(mm_req), .rsp(mm_rsp));

	// effective log length, clamped to 1..LOG_MAX_LENGTH, and length 2^lg
	always_comb begin
		lg = {1'b0, log_length_q};
		if (lg == 5'd0) lg = 5'd1;
		if (lg > 5'(L)) lg = 5'(L);
		len = (L+1)'(1) << lg;
	end

	// bit-reversed partner of i_q
	always_comb begin
		for (int b = 0; b < L; b++) rev_full[b] = i_q[L-1-b];
		r_idx = {1'b0, rev_full} >> (5'(L) - lg);
	end

	// butterfly addresses from the flat butterfly counter
	always_comb begin
		bf_ext = {1'b0, bf_q};
		half = (L+1)'(1) << (s_q - 5'd1);
		hi = (bf_ext >> (s_q - 5'd1)) << s_q;
		kk = hi | (bf_ext & (half - (L+1)'(1)));
		kh = kk | half;
		off_zero = ((bf_ext & (half - (L+1)'(1))) == '0);
	end

	assign in_acc = samples.valid && samples.ready;
	assign samples.ready = (st_q == S_IDLE) && !rd_pend_q
		&& (samples.data.command == CMD_LOAD || !out_valid_q);
	assign cfg.ready = 1'b1;
	assign red_sample = (samples.data.sample >= NTT_P) ? samples.data.sample - NTT_P
		: samples.data.sample;

	// memory port and multiplier request steering
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = lp_q[L-1:0];
		mem_wdata = red_sample;
		mem_raddr = rp_q[L-1:0];
		mm_req = '0;
		case (st_q)
			S_IDLE: mem_we = in_acc && samples.data.command == CMD_LOAD && lp_q < len;
			S_BR: mem_raddr = i_q[L-1:0];
			S_BR_A, S_BR_B: mem_raddr = r_idx[L-1:0];
			S_BR_C: begin
				mem_we = 1'b1;
				mem_waddr = i_q[L-1:0];
				mem_wdata = mem_rdata;
			end
			S_BR_D: begin
				mem_we = 1'b1;
				mem_waddr = r_idx[L-1:0];
				mem_wdata = u_q;
			end
			S_SQ: begin
				mm_req.start = (cnt_q != 5'd0);
				mm_req.a = wn_q;
				mm_req.b = wn_q;
			end
			S_BF_RD1: mem_raddr = kk[L-1:0];
			S_BF_RD2, S_BF_CAP: mem_raddr = kh[L-1:0];
			S_BF_MS: begin
				mm_req.start = 1'b1;
				mm_req.a = w_q;
				mm_req.b = mem_rdata;
			end
			S_BF_WR1: begin
				mem_we = 1'b1;
				mem_waddr = kk[L-1:0];
				mem_wdata = mod_add(u_q, t_q);
			end
			S_BF_WR2: begin
				mem_we = 1'b1;
				mem_waddr = kh[L-1:0];
				mem_wdata = mod_sub(u_q, t_q);
				mm_req.start = 1'b1;
				mm_req.a = w_q;
				mm_req.b = wn_q;
			end
			S_SC_POW: begin
				mm_req.start = (cnt_q != 5'd0);
				mm_req.a = wn_q;
				mm_req.b = NTT_INV2;
			end
			S_SC_RD: mem_raddr = i_q[L-1:0];
			S_SC_CAP: begin
				mm_req.start = 1'b1;
				mm_req.a = mem_rdata;
				mm_req.b = wn_q;
			end
			S_SC_W: begin
				mem_we = mm_rsp.done;
				mem_waddr = i_q[L-1:0];
				mem_wdata = mm_rsp.res;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			out_q.element <= mem_rdata;
			out_q.final_element <= fin_pend_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data = out_q;

	// sequencer, pointers and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			log_length_q <= NTT_LOG_LEN_RESET;
			inverse_q <= 1'b0;
			lp_q <= '0;
			rp_q <= '0;
			done_q <= 1'b0;
			rd_pend_q <= 1'b0;
			fin_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			i_q <= '0;
			bf_q <= '0;
			s_q <= 5'd1;
			cnt_q <= 5'd0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_LOG_LENGTH: log_length_q <= cfg.data.value;
					CFG_INVERSE: inverse_q <= cfg.data.value[0];
					default: ;
				endcase
			end
			rd_pend_q <= 1'b0;
			if (rd_pend_q) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (in_acc && samples.data.command == CMD_LOAD) begin
						done_q <= 1'b0;
						rp_q <= '0;
						if (lp_q < len) lp_q <= lp_q + (L+1)'(1);
						else lp_q <= len;
						if (samples.data.final_sample) begin
							i_q <= '0;
							st_q <= S_BR;
						end
					end else if (in_acc && done_q) begin
						if (rp_q >= len) begin
							done_q <= 1'b0;
							rp_q <= '0;
						end else begin
							rd_pend_q <= 1'b1;
							fin_pend_q <= (rp_q == len - (L+1)'(1));
							if (rp_q == len - (L+1)'(1)) begin
								done_q <= 1'b0;
								rp_q <= '0;
							end else begin
								rp_q <= rp_q + (L+1)'(1);
							end
						end
					end
				end
				// bit-reversal reorder
				S_BR: begin
					if (i_q == len) begin
						s_q <= 5'd1;
						st_q <= S_STG;
					end else if (i_q < r_idx) begin
						st_q <= S_BR_A;
					end else begin
						i_q <= i_q + (L+1)'(1);
					end
				end
				S_BR_A: begin
					u_q <= mem_rdata;
					st_q <= S_BR_B;
				end
				S_BR_B: st_q <= S_BR_C;
				S_BR_C: st_q <= S_BR_D;
				S_BR_D: begin
					i_q <= i_q + (L+1)'(1);
					st_q <= S_BR;
				end
				// pass setup: twiddle base by repeated squaring; after the last pass, scaling or finish
				S_STG: begin
					if (s_q > lg) begin
						if (inverse_q) begin
							wn_q <= 30'd1;
							cnt_q <= lg;
							st_q <= S_SC_POW;
						end else begin
							st_q <= S_FIN;
						end
					end else begin
						wn_q <= inverse_q ? NTT_ROOT_INV : NTT_ROOT_FWD;
						cnt_q <= 5'(NTT_ROOT_LOG) - s_q;
						st_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == 5'd0) begin
						bf_q <= '0;
						st_q <= S_BF_RD1;
					end else begin
						st_q <= S_SQ_W;
					end
				end
				S_SQ_W: begin
					if (mm_rsp.done) begin
						wn_q <= mm_rsp.res;
						cnt_q <= cnt_q - 5'd1;
						st_q <= S_SQ;
					end
				end
				// butterflies
				S_BF_RD1: begin
					if (bf_ext == (len >> 1)) begin
						s_q <= s_q + 5'd1;
						st_q <= S_STG;
					end else begin
						if (off_zero) w_q <= 30'd1;
						st_q <= S_BF_RD2;
					end
				end
				S_BF_RD2: begin
					u_q <= mem_rdata;
					st_q <= S_BF_CAP;
				end
				S_BF_CAP: st_q <= S_BF_MS;
				S_BF_MS: st_q <= S_BF_MW;
				S_BF_MW: begin
					if (mm_rsp.done) begin
						t_q <= mm_rsp.res;
						st_q <= S_BF_WR1;
					end
				end
				S_BF_WR1: st_q <= S_BF_WR2;
				S_BF_WR2: st_q <= S_BF_WW;
				S_BF_WW: begin
					if (mm_rsp.done) begin
						w_q <= mm_rsp.res;
						bf_q <= bf_q + L'(1);
						st_q <= S_BF_RD1;
					end
				end
				// inverse scaling by (1/2)^lg
				S_SC_POW: begin
					if (cnt_q == 5'd0) begin
						i_q <= '0;
						st_q <= S_SC_RD;
					end else begin
						st_q <= S_SC_POW_W;
					end
				end
				S_SC_POW_W: begin
					if (mm_rsp.done) begin
						wn_q <= mm_rsp.res;
						cnt_q <= cnt_q - 5'd1;
						st_q <= S_SC_POW;
					end
				end
				S_SC_RD: begin
					if (i_q == len) st_q <= S_FIN;
					else st_q <= S_SC_CAP;
				end
				S_SC_CAP: st_q <= S_SC_W;
				S_SC_W: begin
					if (mm_rsp.done) begin
						i_q <= i_q + (L+1)'(1);
						st_q <= S_SC_RD;
					end
				end
				S_FIN: begin
					lp_q <= '0;
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/ntt_chk.sv */
// ntt_chk: port-level checker for the ntt core, with its bind
// depends on ntt_pkg; attaches to number_theoretic_transform_core
module ntt_chk import ntt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// elements are always reduced
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.element < NTT_P)
		else $error("element not below modulus");

	// a final load starts the transform, so the core is busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.command == CMD_LOAD && in_data.final_sample
		|=> !in_ready)
		else $error("core ready right after final load");

	// a load accepted while no result is shown never brings one up out of nothing
	a_noload: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.command == CMD_LOAD && !out_valid
		|=> !out_valid)
		else $error("result appeared after a load");

endmodule

bind number_theoretic_transform_core ntt_chk u_ntt_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samples.valid),
	.in_ready(samples.ready),
	.in_data(samples.data),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_data(results.data)
);

/* bench/tb_number_theoretic_transform_core.sv */
// tb_number_theoretic_transform_core: self-checking bench for the ntt core
// depends on ntt_pkg, ntt_if and the number_theoretic_transform_core rtl
// a directed table, then random load/transform/read phases, checked by a predictor
module tb_number_theoretic_transform_core;
	import ntt_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int TARGET_ITEMS = 800;
	localparam int MAX_DEPTH = 4096;
	localparam longint unsigned PRIME = 64'd998244353;

	typedef struct packed {
		logic is_cfg;
		logic cfg_idx;
		logic [3:0] cfg_val;
		in_item_t item;
		logic typed;
		out_item_t want;
	} row_t;

	logic clk;
	logic arst_n;

	ntt_in_if samples_if();
	ntt_out_if results_if();
	ntt_cfg_if cfg_if();

	number_theoretic_transform_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	// predictor state
	logic [NTT_W-1:0] coeff_mem [MAX_DEPTH];
	int unsigned load_ptr;
	int unsigned read_ptr;
	bit done_flag;
	logic [3:0] log_reg;
	bit inv_reg;
	int unsigned filled;

	out_item_t pending_elements [$];
	int fail_count;
	int idle_cycles;
	int tx_gap_max;
	int rx_gap_max;
	int n_loads, n_reads, n_results, n_transforms, n_phases;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [NTT_W-1:0] mmul(logic [NTT_W-1:0] a, logic [NTT_W-1:0] b);
		longint unsigned p;
		p = longint'(a) * longint'(b);
		return NTT_W'(p % PRIME);
	endfunction

	function automatic logic [NTT_W-1:0] mpow(logic [NTT_W-1:0] base, longint unsigned e);
		logic [NTT_W-1:0] r;
		r = 1;
		while (e != 0) begin
			if (e[0]) r = mmul(r, base);
			base = mmul(base, base);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic int unsigned eff_log();
		int unsigned l;
		l = log_reg;
		if (l < 1) l = 1;
		if (l > 12) l = 12;
		return l;
	endfunction

	// in-place transform over the first 2^lg entries
	function automatic void compute_ntt(int unsigned lg);
		int unsigned len, r, t, half;
		logic [NTT_W-1:0] tmp, wn, w, u, v;
		len = 1 << lg;
		for (int unsigned i = 0; i < len; i++) begin
			r = 0;
			t = i;
			for (int unsigned b = 0; b < lg; b++) begin
				r = (r << 1) | (t & 1);
				t = t >> 1;
			end
			if (i < r) begin
				tmp = coeff_mem[i];
				coeff_mem[i] = coeff_mem[r];
				coeff_mem[r] = tmp;
			end
		end
		for (int unsigned h = 2; h <= len; h = h << 1) begin
			half = h >> 1;
			wn = mpow(3, (PRIME - 1) / h);
			if (inv_reg) wn = mpow(wn, PRIME - 2);
			for (int unsigned j = 0; j < len; j += h) begin
				w = 1;
				for (int unsigned k = j; k < j + half; k++) begin
					u = coeff_mem[k];
					v = mmul(w, coeff_mem[k + half]);
					coeff_mem[k] = NTT_W'((longint'(u) + longint'(v)) % PRIME);
					coeff_mem[k + half] = NTT_W'((longint'(u) + PRIME - longint'(v)) % PRIME);
					w = mmul(w, wn);
				end
			end
		end
		if (inv_reg) begin
			tmp = mpow(NTT_W'(len), PRIME - 2);
			for (int unsigned i = 0; i < len; i++) coeff_mem[i] = mmul(coeff_mem[i], tmp);
		end
	endfunction

	// one accepted request; returns 1 when it yields an element
	function automatic bit predict_element(in_item_t it, output out_item_t res);
		int unsigned lg, len;
		logic [NTT_W-1:0] s;
		lg = eff_log();
		len = 1 << lg;
		res = '0;
		if (it.command == CMD_LOAD) begin
			s = it.sample;
			if (s >= NTT_P) s = s - NTT_P;
			done_flag = 0;
			read_ptr = 0;
			if (load_ptr < len) begin
				coeff_mem[load_ptr] = s;
				load_ptr++;
				if (load_ptr > filled) filled = load_ptr;
			end else begin
				load_ptr = len;
			end
			if (it.final_sample) begin
				compute_ntt(lg);
				load_ptr = 0;
				done_flag = 1;
				n_transforms++;
			end
			return 0;
		end
		if (!done_flag) return 0;
		if (read_ptr >= len) begin
			done_flag = 0;
			read_ptr = 0;
			return 0;
		end
		res.element = coeff_mem[read_ptr];
		if (read_ptr == len - 1) begin
			res.final_element = 1;
			done_flag = 0;
			read_ptr = 0;
		end else begin
			res.final_element = 0;
			read_ptr++;
		end
		return 1;
	endfunction

	// a final load may only transform entries that were written before
	function automatic bit final_allowed();
		int unsigned len, reach;
		len = 1 << eff_log();
		reach = (load_ptr < len) ? load_ptr + 1 : len;
		return (filled >= len) || (reach >= len);
	endfunction

	function automatic row_t load_row(logic [NTT_W-1:0] s, logic fin);
		row_t r;
		r = '0;
		r.item.command = CMD_LOAD;
		r.item.sample = s;
		r.item.final_sample = fin;
		return r;
	endfunction

	function automatic row_t read_row(logic typed, logic [NTT_W-1:0] e, logic fin);
		row_t r;
		r = '0;
		r.item.command = CMD_READ;
		r.item.sample = NTT_W'($urandom);
		r.item.final_sample = 1'($urandom_range(0, 1));
		r.typed = typed;
		r.want.element = e;
		r.want.final_element = fin;
		return r;
	endfunction

	function automatic row_t cfg_row(logic idx, logic [3:0] val);
		row_t r;
		r = '0;
		r.is_cfg = 1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	// one request on samples, predicted when accepted
	task automatic send_request(row_t r);
		out_item_t res;
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			samples_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid = 1'b1;
		samples_if.data = r.item;
		do @(posedge clk); while (!samples_if.ready);
		if (r.item.command == CMD_LOAD) n_loads++;
		else n_reads++;
		if (predict_element(r.item, res)) begin
			if (r.typed) pending_elements.push_back(r.want);
			else pending_elements.push_back(res);
		end
	endtask

	// wait until every element arrived and the core has settled
	task automatic wait_drained();
		@(negedge clk);
		samples_if.valid = 1'b0;
		while (pending_elements.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [3:0] val);
		wait_drained();
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.data.index = idx;
		cfg_if.data.value = val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == CFG_LOG_LENGTH) log_reg = val;
		else inv_reg = val[0];
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	function automatic logic [NTT_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return NTT_P - 1;
			2: return '1;
			default: return NTT_W'($urandom);
		endcase
	endfunction

	// one random phase: mostly load-transform-read sequences, some noise
	task automatic random_phase(int unsigned len);
		int unsigned n_rd;
		row_t r;
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 1)) send_request(read_row(0, 0, 0));
				else send_request(load_row(rand_sample(), 0));
			end
			r = load_row(rand_sample(), 0);
			if (i == len - 1 || $urandom_range(0, 49) == 0) begin
				r.item.final_sample = final_allowed();
				send_request(r);
				if (r.item.final_sample) break;
			end else begin
				send_request(r);
			end
		end
		case ($urandom_range(0, 9))
			0: n_rd = $urandom_range(0, len);
			1: n_rd = len + $urandom_range(1, 3);
			default: n_rd = len;
		endcase
		for (int unsigned i = 0; i < n_rd; i++) send_request(read_row(0, 0, 0));
		send_request(read_row(0, 0, 0));
	endtask

	// result side: random stalls on ready
	initial begin
		int gap;
		results_if.ready = 1'b0;
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			@(negedge clk);
			if (gap > 0) begin
				results_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			results_if.ready = 1'b1;
			do @(posedge clk); while (!results_if.valid);
		end
	end

	// compare each element with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			n_results++;
			if (pending_elements.size() == 0) begin
				$error("element with nothing pending: %0d", results_if.data.element);
				fail_count++;
			end else begin
				want = pending_elements.pop_front();
				if (results_if.data.element !== want.element) begin
					$error("element expected %0d actual %0d", want.element,
						results_if.data.element);
					fail_count++;
				end
				if (results_if.data.final_element !== want.final_element) begin
					$error("final_element expected %0d actual %0d", want.final_element,
						results_if.data.final_element);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake on samples, results or cfg
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// main sequence
	initial begin
		row_t directed_rows [];
		int unsigned lg;
		samples_if.valid = 1'b0;
		samples_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		idle_cycles = 0;
		fail_count = 0;
		n_loads = 0;
		n_reads = 0;
		n_results = 0;
		n_transforms = 0;
		n_phases = 0;
		load_ptr = 0;
		read_ptr = 0;
		done_flag = 0;
		log_reg = NTT_LOG_LEN_RESET;
		inv_reg = 0;
		filled = 0;
		tx_gap_max = 4;
		rx_gap_max = 4;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: length clamp, both directions, reduction, overflow, abandon
		directed_rows = '{
			cfg_row(CFG_LOG_LENGTH, 4'd0),
			cfg_row(CFG_INVERSE, 4'd0),
			read_row(0, 0, 0),
			load_row(30'd5, 0),
			load_row(30'd7, 1),
			read_row(1, 30'd12, 0),
			read_row(1, 30'd998244351, 1),
			read_row(0, 0, 0),
			cfg_row(CFG_INVERSE, 4'd1),
			load_row(30'd12, 0),
			load_row(30'd998244351, 1),
			read_row(1, 30'd5, 0),
			read_row(1, 30'd7, 1),
			cfg_row(CFG_LOG_LENGTH, 4'd2),
			cfg_row(CFG_INVERSE, 4'd0),
			load_row(30'h3FFFFFFF, 0),
			load_row(30'd998244352, 0),
			load_row(30'd0, 0),
			load_row(30'd1, 0),
			load_row(30'd2, 0),
			load_row(30'd3, 1),
			read_row(0, 0, 0),
			read_row(0, 0, 0),
			cfg_row(CFG_LOG_LENGTH, 4'd1),
			read_row(0, 0, 0),
			load_row(30'd9, 0),
			read_row(0, 0, 0),
			load_row(30'd4, 1),
			read_row(0, 0, 0),
			load_row(30'd6, 0),
			load_row(30'd8, 1),
			read_row(0, 0, 0),
			read_row(0, 0, 0)
		};
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
			else
				send_request(directed_rows[i]);
		end

		// random phases
		while (n_loads + n_reads < TARGET_ITEMS) begin
			case ($urandom_range(0, 9))
				0: lg = 0;
				1: lg = $urandom_range(6, 8);
				default: lg = $urandom_range(1, 5);
			endcase
			write_cfg(CFG_LOG_LENGTH, 4'(lg));
			write_cfg(CFG_INVERSE, 4'($urandom_range(0, 1)));
			tx_gap_max = $urandom_range(0, 3) == 0 ? 0 : 16;
			rx_gap_max = $urandom_range(0, 3) == 0 ? 0 : 16;
			if ($urandom_range(0, 3) == 0) begin
				// hold the sender until everything pending has drained
				random_phase(1 << eff_log());
				wait_drained();
			end
			random_phase(1 << eff_log());
			n_phases++;
		end

		wait_drained();
		if (pending_elements.size() != 0) begin
			$error("%0d elements never arrived", pending_elements.size());
			fail_count++;
		end
		$display("covered %0d loads, %0d reads, %0d transforms, %0d elements in %0d phases",
			n_loads, n_reads, n_transforms, n_results, n_phases);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ntt_pkg.sv
rtl/ntt_if.sv
rtl/ntt_mulmod.sv
rtl/ntt_buf.sv
rtl/number_theoretic_transform_core.sv
rtl/ntt_chk.sv
bench/tb_number_theoretic_transform_core.sv
